// ===== rtl/grid_strict_peak_finder_defines.svh =====
// assertion helpers for the peak finder checker
`ifndef GRID_STRICT_PEAK_FINDER_DEFINES_SVH
`define GRID_STRICT_PEAK_FINDER_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define GSPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also covers the reset cycles
`define GSPF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/gspf_pkg.sv =====
package gspf_pkg;

  localparam int GSPF_MAX_ROWS   = 1024;
  localparam int GSPF_MAX_COLS   = 1024;
  localparam int GSPF_PIXEL_BITS = 20;

  localparam int DIM_W       = 11;
  localparam int TOTAL_W     = 21;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_TDATA_W = 48;
  localparam int QUEUE_DEPTH = 4;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic {
    KIND_PEAK  = 1'b0,
    KIND_COUNT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [TOTAL_W-1:0] total;
  } result_t;

  // out_tdata layout, lowest field last
  typedef struct packed {
    logic [OUT_TDATA_W-TOTAL_W-2*DIM_W-1:0] pad;
    logic [TOTAL_W-1:0]                     total;
    logic [DIM_W-1:0]                       col;
    logic [DIM_W-1:0]                       row;
  } out_data_t;

endpackage

// ===== rtl/grid_strict_peak_finder.sv =====
// channel  | direction | handshake         | payload
// in_      | input     | tvalid / tready   | tdata: pixel_value; tuser: operation
// out_     | output    | tvalid / tready   | tdata: row, col, total; tuser: kind; tlast
// cfg_     | input     | we, no wait       | index: register; data: 11-bit value
//
// one input item per clock while in_tready is high; the decision for a cell is made
// in the cycle the request is taken, the result is offered on out_ from the result queue
// the two-port column buffer is read ahead at the next position (pos_nxt),
// so consecutive pixels run back to back with no bubble
// in_tready drops only when the four-entry result queue has under two free slots
// rst_n (synchronous) clears counters, the queue and sets the grid to 1 x 1;
// the column buffer is not cleared, every cell is written before it is read
module grid_strict_peak_finder import gspf_pkg::*; #(
  parameter  int MAX_ROWS   = GSPF_MAX_ROWS,
  parameter  int MAX_COLS   = GSPF_MAX_COLS,
  parameter  int PIXEL_BITS = GSPF_PIXEL_BITS,
  localparam int IN_TDATA_W = ((PIXEL_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pixel_value, then zero pad
  input  logic                   in_tuser,   // operation
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // peak_row, peak_col, peak_total, pad
  output logic                   out_tuser,  // kind
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_data
);

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CDW = $clog2(MAX_COLS + 1);
  localparam int RDW = $clog2(MAX_ROWS + 1);
  localparam int PB  = PIXEL_BITS;

  // configuration
  logic [DIM_W-1:0]   grid_rows_r, grid_cols_r;
  logic [RDW-1:0]     rows_eff;
  logic [CDW-1:0]     cols_eff;

  // position and frame state; one pointer serves as column and drain counter
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic               done_r, done_nxt;
  logic [TOTAL_W-1:0] peak_cnt_r, peak_cnt_nxt, peak_cnt_sat;
  logic [PB-1:0]      left_r, left_nxt;

  // column buffer: upper row in the high half, middle row in the low half
  logic [2*PB-1:0]    rd_a, rd_b, wr_data;
  logic [CW-1:0]      rd_addr_b;

  logic [PB-1:0]      pix, self_v, up_v, right_v;
  op_t                op;
  logic               acc, step_pix, step_drn, step;
  logic [CDW-1:0]     pos_inc;
  logic [RDW-1:0]     row_inc;
  logic               pos_last, row_last, pos_in_grid, pos_nz, has_right;
  logic               gt_up, gt_down, gt_left, gt_right;
  logic               peak_pix, peak_drn, found, frame_end;

  result_t            peak_res, cnt_res, res0;
  result_t            head;
  logic [1:0]         push_cnt;
  logic               room;
  out_data_t          od;

  // register port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= DIM_W'(1);
      grid_cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_ROWS: grid_rows_r <= cfg_data;
        CFG_GRID_COLS: grid_cols_r <= cfg_data;
        default:       grid_rows_r <= grid_rows_r;
      endcase
    end
  end

  // grid size clamped to 1..max
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = RDW'(1);
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(grid_rows_r);
    end
    if (grid_cols_r == '0) begin
      cols_eff = CDW'(1);
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(grid_cols_r);
    end
  end

  assign op  = op_t'(in_tuser);
  assign pix = in_tdata[PB-1:0];
  assign acc = in_tvalid && in_tready;

  // pixels after frame end and drains before it are taken and dropped
  assign step_pix = acc && (op == OP_PIXEL) && !done_r;
  assign step_drn = acc && (op == OP_DRAIN) && done_r;
  assign step     = step_pix || step_drn;

  // the cell being decided sits in the middle row at the current position
  assign self_v  = rd_a[PB-1:0];
  assign up_v    = rd_a[2*PB-1:PB];
  assign right_v = rd_b[PB-1:0];

  assign pos_inc     = CDW'(pos_r) + CDW'(1);
  assign row_inc     = RDW'(row_r) + RDW'(1);
  assign pos_last    = (pos_inc >= cols_eff);
  assign row_last    = (row_inc >= rows_eff);
  assign pos_in_grid = (CDW'(pos_r) < cols_eff);
  assign pos_nz      = (pos_r != '0);
  assign has_right   = !pos_last;

  assign gt_up    = (self_v > up_v);
  assign gt_down  = (self_v > pix);
  assign gt_left  = (self_v > left_r);
  assign gt_right = (self_v > right_v);

  // pixel: decide the cell above it, which has an upper neighbor past row 1
  assign peak_pix = (row_r != '0) && ((row_r <= RW'(1)) || gt_up) && gt_down &&
                    (!pos_nz || gt_left) && (!has_right || gt_right);
  // drain: decide a cell of the last row, no neighbor below
  assign peak_drn = pos_in_grid && ((rows_eff <= RDW'(1)) || gt_up) &&
                    (!pos_nz || gt_left) && (!has_right || gt_right);

  assign found     = (step_pix && peak_pix) || (step_drn && peak_drn);
  assign frame_end = step_drn && pos_last;

  // peak count saturates
  assign peak_cnt_sat = (found && (peak_cnt_r != '1)) ? peak_cnt_r + TOTAL_W'(1)
                                                      : peak_cnt_r;

  always_comb begin
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    done_nxt     = done_r;
    left_nxt     = left_r;
    peak_cnt_nxt = peak_cnt_sat;
    if (step) begin
      left_nxt = self_v;
      pos_nxt  = pos_last ? '0 : CW'(pos_inc);
    end
    if (step_pix && pos_last) begin
      if (row_last) begin
        row_nxt  = '0;
        done_nxt = 1'b1;
      end else begin
        row_nxt = RW'(row_inc);
      end
    end
    if (frame_end) begin
      row_nxt      = '0;
      done_nxt     = 1'b0;
      peak_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      row_r      <= '0;
      done_r     <= 1'b0;
      peak_cnt_r <= '0;
    end else begin
      pos_r      <= pos_nxt;
      row_r      <= row_nxt;
      done_r     <= done_nxt;
      peak_cnt_r <= peak_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
  end

  // a pixel moves the middle cell up and becomes the new middle cell
  assign wr_data   = {self_v, pix};
  assign rd_addr_b = (32'(pos_nxt) == MAX_COLS - 1) ? '0 : pos_nxt + CW'(1);

  gspf_line_buf #(
    .DEPTH (MAX_COLS),
    .WIDTH (2 * PB)
  ) u_line_buf (
    .clk       (clk),
    .wr_en     (step_pix),
    .wr_addr   (pos_r),
    .wr_data   (wr_data),
    .rd_addr_a (pos_nxt),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // results of this request
  always_comb begin
    peak_res.kind  = KIND_PEAK;
    peak_res.row   = step_drn ? DIM_W'(rows_eff) : DIM_W'(row_r);
    peak_res.col   = DIM_W'(pos_inc);
    peak_res.total = '0;
    cnt_res.kind   = KIND_COUNT;
    cnt_res.row    = '0;
    cnt_res.col    = '0;
    cnt_res.total  = peak_cnt_sat;
    res0           = found ? peak_res : cnt_res;
    push_cnt       = 2'(found) + 2'(frame_end);
  end

  gspf_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_res0 (res0),
    .push_res1 (cnt_res),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  assign in_tready = room;

  always_comb begin
    od.pad   = '0;
    od.total = head.total;
    od.col   = head.col;
    od.row   = head.row;
  end

  assign out_tdata = od;
  assign out_tuser = head.kind;
  assign out_tlast = (head.kind == KIND_COUNT);

endmodule

// ===== rtl/gspf_line_buf.sv =====
// two rows per column in one word, one write and two registered reads,
// write data forwarded when a read hits the address being written
module gspf_line_buf import gspf_pkg::*; #(
  parameter  int DEPTH = GSPF_MAX_COLS,
  parameter  int WIDTH = 2 * GSPF_PIXEL_BITS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr_a)) begin
      rd_a_r <= wr_data;
    end else begin
      rd_a_r <= mem[rd_addr_a];
    end
    if (wr_en && (wr_addr == rd_addr_b)) begin
      rd_b_r <= wr_data;
    end else begin
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== rtl/gspf_out_queue.sv =====
// small result queue, takes up to two results a cycle, hands out one while out_ready is high
module gspf_out_queue import gspf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push_res0,
  input  result_t    push_res1,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  result_t         slots_r [QUEUE_DEPTH];
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   wr_ptr_inc;
  logic [QW-1:0]   count_r, count_nxt;
  logic            pop;

  assign out_valid  = (count_r != '0);
  assign pop        = out_valid && out_ready;
  assign out_res    = slots_r[rd_ptr_r];
  // room for a worst-case item (peak plus count report)
  assign room       = (count_r <= QW'(QUEUE_DEPTH - 2));
  assign wr_ptr_inc = wr_ptr_r + PW'(1);

  always_comb begin
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    count_nxt  = count_r + QW'(push_cnt) - QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slots_r[wr_ptr_r] <= push_res0;
    end
    if (push_cnt == 2'd2) begin
      slots_r[wr_ptr_inc] <= push_res1;
    end
  end

endmodule

// ===== rtl/gspf_checker.sv =====
`include "grid_strict_peak_finder_defines.svh"

module gspf_checker import gspf_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  out_data_t od;

  assign od = out_tdata;

  // nothing offered right after reset
  `GSPF_ASSERT_RST(a_idle_after_reset, !rst_n |=> !out_tvalid, "result offered after reset")

  // tlast marks exactly the count report
  `GSPF_ASSERT(a_last_is_count, out_tvalid |-> (out_tlast == (out_tuser == KIND_COUNT)), "tlast and kind disagree")

  // position report: 1-based position, no total
  `GSPF_ASSERT(a_peak_fields, (out_tvalid && (out_tuser == KIND_PEAK)) |-> ((od.row != '0) && (od.col != '0) && (od.total == '0)), "bad peak report fields")

  // stalled result holds
  `GSPF_ASSERT(a_hold_on_stall, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result changed while stalled")

endmodule

bind grid_strict_peak_finder gspf_checker u_gspf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
